[rtl/in_order_release_buffer_defines.svh]
// assertion macros for the in-order release buffer
`ifndef IN_ORDER_RELEASE_BUFFER_DEFINES_SVH
`define IN_ORDER_RELEASE_BUFFER_DEFINES_SVH

`ifndef ASSERT_OFF
`define IORB_ASSERT_IMPLY(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("iorb same-cycle check failed");
`define IORB_ASSERT_NEXT(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("iorb next-cycle check failed");
`else
`define IORB_ASSERT_IMPLY(lbl, cond, prop)
`define IORB_ASSERT_NEXT(lbl, cond, prop)
`endif

`endif

[rtl/iorb_pkg.sv]
// shared types, constants and status codes of the in-order release buffer
package iorb_pkg;

	localparam int unsigned WINDOW_DEPTH = 16;
	localparam int unsigned SLOT_W = $clog2(WINDOW_DEPTH);
	localparam int unsigned SEQ_W = 32;
	localparam int unsigned PAY_W = 32;
	localparam int unsigned STAT_W = 2;

	localparam logic [STAT_W-1:0] ST_RELEASED = 2'd0;
	localparam logic [STAT_W-1:0] ST_REJ_STALE = 2'd1;
	localparam logic [STAT_W-1:0] ST_REJ_BEYOND = 2'd2;

	typedef struct packed {
		logic [SEQ_W-1:0] seq;
		logic [PAY_W-1:0] payload;
	} item_t;

	typedef struct packed {
		logic valid;
		item_t item;
	} queue_head_t;

	typedef struct packed {
		logic [PAY_W-1:0] payload;
		logic [SEQ_W-1:0] seq;
		logic [STAT_W-1:0] status;
		logic last;
	} result_t;

endpackage

[rtl/iorb_front.sv]
// front side: accepts arriving items into a two-entry queue
module iorb_front import iorb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             arrive_valid,
	output logic             arrive_stall,
	input  logic [SEQ_W-1:0] sequence_number,
	input  logic [PAY_W-1:0] payload_handle,
	output queue_head_t      head,
	input  logic             pop
);

	item_t       mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;
	logic        do_pop;

	assign arrive_stall = (count_q == 2'd2);
	assign push = arrive_valid && !arrive_stall;
	assign do_pop = pop && (count_q != 2'd0);

	assign head.valid = (count_q != 2'd0);
	assign head.item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			priority if (push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 2'd1;
			end else begin
				count_q <= count_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{seq: sequence_number, payload: payload_handle};
		end
	end

endmodule

[rtl/iorb_back.sv]
// back side: classifies queued items, holds the window store and drains runs
module iorb_back import iorb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [SEQ_W-1:0] first_sequence,
	input  queue_head_t      head,
	output logic             pop,
	output logic             release_valid,
	input  logic             release_stall,
	output result_t          result
);

	typedef enum logic [1:0] {
		S_IDLE  = 2'b01,
		S_DRAIN = 2'b10
	} state_t;

	localparam logic [SLOT_W:0] DEPTH_X = (SLOT_W + 1)'(WINDOW_DEPTH);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);

	state_t                  state_q;
	state_t                  state_d;
	logic [SEQ_W-1:0]        next_exp_q;
	logic [SLOT_W-1:0]       head_q;
	logic [WINDOW_DEPTH-1:0] valid_q;
	logic [PAY_W-1:0]        pay_mem [WINDOW_DEPTH];
	logic [PAY_W-1:0]        rd_data_q;
	result_t                 out_q;
	logic                    out_valid_q;

	logic [SEQ_W-1:0]  seq_delta;
	logic              is_stale;
	logic              is_beyond;
	logic              is_now;
	logic              is_dup;
	logic [SLOT_W:0]   slot_sum;
	logic [SLOT_W-1:0] slot;
	logic [SLOT_W-1:0] head_inc;
	logic              next_more;
	logic              out_free;
	logic              cfg_write;
	logic              emit;
	logic              advance;
	logic              store;
	result_t           res;

	assign cfg_ready = (state_q == S_IDLE);
	assign cfg_write = cfg_valid && cfg_ready;

	assign seq_delta = head.item.seq - next_exp_q;
	assign is_stale = seq_delta[SEQ_W-1];
	assign is_beyond = !is_stale && (seq_delta >= SEQ_W'(WINDOW_DEPTH));
	assign is_now = (seq_delta == '0);
	assign slot_sum = {1'b0, head_q} + {1'b0, seq_delta[SLOT_W-1:0]};
	assign slot = (slot_sum >= DEPTH_X) ? SLOT_W'(slot_sum - DEPTH_X) : slot_sum[SLOT_W-1:0];
	assign is_dup = !is_stale && !is_beyond && !is_now && valid_q[slot];
	assign head_inc = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
	assign next_more = valid_q[head_inc];
	assign out_free = !out_valid_q || !release_stall;

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		emit = 1'b0;
		advance = 1'b0;
		store = 1'b0;
		res = '{payload: head.item.payload, seq: head.item.seq,
			status: ST_RELEASED, last: 1'b1};
		unique case (state_q)
			S_IDLE: begin
				if (head.valid) begin
					priority if (!is_stale && !is_beyond && !is_now && !is_dup) begin
						pop = 1'b1;
						store = 1'b1;
					end else if (out_free) begin
						pop = 1'b1;
						emit = 1'b1;
						priority if (is_stale || is_dup) begin
							res.status = ST_REJ_STALE;
						end else if (is_beyond) begin
							res.status = ST_REJ_BEYOND;
						end else begin
							advance = 1'b1;
							res.last = !next_more;
							if (next_more) state_d = S_DRAIN;
						end
					end else begin
						pop = 1'b0;
					end
				end
			end
			S_DRAIN: begin
				if (out_free) begin
					emit = 1'b1;
					advance = 1'b1;
					res = '{payload: rd_data_q, seq: next_exp_q,
						status: ST_RELEASED, last: !next_more};
					if (!next_more) state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			next_exp_q <= '0;
			head_q <= '0;
			valid_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				next_exp_q <= first_sequence;
				head_q <= '0;
				valid_q <= '0;
				state_q <= S_IDLE;
			end else begin
				if (advance) begin
					valid_q[head_q] <= 1'b0;
					head_q <= head_inc;
					next_exp_q <= next_exp_q + 1'b1;
				end
				if (store) valid_q[slot] <= 1'b1;
				state_q <= state_d;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!release_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store) pay_mem[slot] <= head.item.payload;
		if (advance) rd_data_q <= pay_mem[head_inc];
		if (emit) out_q <= res;
	end

	assign release_valid = out_valid_q;
	assign result = out_q;

endmodule

[rtl/in_order_release_buffer.sv]
// top level of the in-order release buffer
//
//  channel   signals                                     direction
//  arrive    arrive_valid/arrive_stall, seq + payload    in
//  release   release_valid/release_stall, result fields  out
//  cfg       cfg_valid/cfg_ready, first_sequence         in
//
// an accepted item is classified combinationally once it is the queue head; a
// stored item only writes the payload store, a rejected or in-order one is
// popped into the result register once the output is free; an in-order item
// then drains each waiting entry behind it, one payload store read per cycle
// reset and a first_sequence write clear all valid marks at once, no sweep
// release_stall holds the output register and the drain; the queue takes items
// until both entries are full, then raises arrive_stall
`include "in_order_release_buffer_defines.svh"

module in_order_release_buffer import iorb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              arrive_valid,
	output logic              arrive_stall,
	input  logic [SEQ_W-1:0]  sequence_number,
	input  logic [PAY_W-1:0]  payload_handle,
	output logic              release_valid,
	input  logic              release_stall,
	output logic [PAY_W-1:0]  released_payload,
	output logic [SEQ_W-1:0]  released_sequence,
	output logic [STAT_W-1:0] status,
	output logic              last_of_run,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [SEQ_W-1:0]  first_sequence
);

	queue_head_t q_head;
	logic        q_pop;
	result_t     result;

	iorb_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.arrive_valid    (arrive_valid),
		.arrive_stall    (arrive_stall),
		.sequence_number (sequence_number),
		.payload_handle  (payload_handle),
		.head            (q_head),
		.pop             (q_pop)
	);

	iorb_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.first_sequence (first_sequence),
		.head           (q_head),
		.pop            (q_pop),
		.release_valid  (release_valid),
		.release_stall  (release_stall),
		.result         (result)
	);

	assign released_payload = result.payload;
	assign released_sequence = result.seq;
	assign status = result.status;
	assign last_of_run = result.last;

	`IORB_ASSERT_IMPLY(a_reject_ends_run, release_valid && (status != ST_RELEASED), last_of_run)
	`IORB_ASSERT_NEXT(a_run_is_consecutive, release_valid && !release_stall && !last_of_run, !release_valid || ((released_sequence - $past(released_sequence)) == 32'd1))
	`IORB_ASSERT_NEXT(a_run_stays_released, release_valid && !release_stall && !last_of_run, !release_valid || (status == ST_RELEASED))

endmodule
